### design/button_debounce_long_press_top_defines.svh
// Assertion macros shared by the debouncer checker.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_TOP_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define BDLP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("debouncer assertion failed");

// Next-cycle implication, disabled during reset
`define BDLP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("debouncer assertion failed");

`endif

### design/bdlp_pkg.sv
// Shared types and constants of the button debouncer with long-press detection.
// No dependencies; imported by every module of the block.
`default_nettype none

package bdlp_pkg;

    // Lane count limit and field widths
    localparam int MAX_BUTTONS   = 8;
    localparam int BUTTONS_DEF   = 8;
    localparam int CNT_W         = 8;
    localparam int STATES_W      = 2 * MAX_BUTTONS;
    localparam int CFG_INDEX_W   = 2;

    // Register reset values
    localparam logic [CNT_W-1:0] DEBOUNCE_RESET   = 8'd5;
    localparam logic [CNT_W-1:0] LONG_PRESS_RESET = 8'd50;
    localparam logic [CNT_W-1:0] RELOAD_RESET     = DEBOUNCE_RESET - 8'd1;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS = 2'd1;

    // Per-button accepted state
    typedef enum logic [1:0] {
        ST_LOW  = 2'd0,
        ST_HIGH = 2'd1,
        ST_LONG = 2'd2
    } btn_state_t;

    // Derived configuration handed to every lane
    typedef struct packed {
        logic [CNT_W-1:0] reload;
        logic [CNT_W-1:0] thresh;
    } lane_cfg_t;

    // One result word
    typedef struct packed {
        logic [MAX_BUTTONS-1:0] event_mask;
        logic [STATES_W-1:0]    button_states;
    } out_word_t;

endpackage

`default_nettype wire

### design/button_debounce_long_press_top.sv
// Button debouncer with long-press detection: config registers, lanes, merge.
// Depends on bdlp_pkg, bdlp_lane and bdlp_merge.
//
// Usage:
//   Input channel (in_valid/in_ready, pin_levels): one word per scan tick, bit i
//   is the raw level of button i, low means pressed. Bits at or above BUTTONS
//   are ignored.
//   Output channel (out_valid/out_ready, event_mask, button_states): exactly one
//   word per input word, in order. event_mask bit i flags an accepted state on
//   button i; button_states holds two bits per button (0 low, 1 high, 2 long).
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 is
//   debounce_count (reset 5), index 1 is long_press_ticks (reset 50); other
//   indexes are dropped. cfg_ready is always high.
//   Each result is registered in the merge buffer before it reaches the output.
//   Throughput: one word per cycle while the result buffer has space; every button
//   is its own lane of combinational compares and registered counter updates.
//   Stall: a two-entry result buffer lets the input side keep going for one
//   word while the receiver stalls; in_ready drops when both entries are full.
//   Reset: every button reads released, run counters at zero, debounce
//   counters at 4, buffer empty.
`default_nettype none

module button_debounce_long_press_top
    import bdlp_pkg::*;
#(
    parameter int BUTTONS = BUTTONS_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [MAX_BUTTONS-1:0]  pin_levels,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [MAX_BUTTONS-1:0]       event_mask,
    output logic [STATES_W-1:0]          button_states,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [CNT_W-1:0]        cfg_data
);

    logic [CNT_W-1:0]       debounce_reg;
    logic [CNT_W-1:0]       long_press_reg;
    lane_cfg_t              lane_cfg;
    logic                   step;
    logic                   space;
    out_word_t              word_in;
    out_word_t              word_out;
    logic [MAX_BUTTONS-1:0] events;
    btn_state_t             states [MAX_BUTTONS];

    assign cfg_ready = 1'b1;
    assign in_ready  = space;
    assign step      = in_valid && space;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DEBOUNCE:   debounce_reg   <= cfg_data;
                REG_LONG_PRESS: long_press_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Clamp zero settings to one
    always_comb
    begin
        lane_cfg.reload = (debounce_reg == '0) ? '0
                          : debounce_reg - {{(CNT_W-1){1'b0}}, 1'b1};
        lane_cfg.thresh = (long_press_reg == '0) ? {{(CNT_W-1){1'b0}}, 1'b1}
                          : long_press_reg;
    end

    // One lane per button; unused lanes read zero
    for (genvar i = 0; i < MAX_BUTTONS; i++)
    begin : g_lane
        if (i < BUTTONS)
        begin : g_used
            bdlp_lane u_lane (
                .clk       (clk),
                .rst_n     (rst_n),
                .step      (step),
                .pin       (pin_levels[i]),
                .cfg       (lane_cfg),
                .event_hit (events[i]),
                .state     (states[i])
            );
        end
        else
        begin : g_unused
            assign events[i] = 1'b0;
            assign states[i] = ST_LOW;
        end
        assign word_in.button_states[2*i +: 2] = states[i];
    end

    assign word_in.event_mask = events;

    bdlp_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .word_in   (word_in),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .word_out  (word_out)
    );

    assign event_mask    = word_out.event_mask;
    assign button_states = word_out.button_states;

endmodule

`default_nettype wire

### design/bdlp_lane.sv
// One button lane: run counter, classification and debounce counter.
// Depends on bdlp_pkg for the state enum and the lane configuration struct.
`default_nettype none

module bdlp_lane
    import bdlp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic       pin,
    input  wire lane_cfg_t  cfg,
    output logic            event_hit,
    output btn_state_t      state
);

    btn_state_t       acc_reg, acc_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic [CNT_W-1:0] run_reg, run_next;
    logic [CNT_W:0]   run_inc;
    btn_state_t       sample;
    logic             differs;

    // Classify the sample and advance the run counter
    always_comb
    begin
        run_inc = {1'b0, run_reg} + {{CNT_W{1'b0}}, 1'b1};
        if (!pin)
        begin
            if (run_inc > {1'b0, cfg.thresh})
            begin
                run_next = cfg.thresh;
                sample   = ST_LONG;
            end
            else
            begin
                run_next = run_inc[CNT_W-1:0];
                sample   = ST_LOW;
            end
        end
        else
        begin
            run_next = '0;
            sample   = ST_HIGH;
        end
    end

    // Count down on a differing sample, accept at zero, reload otherwise
    always_comb
    begin
        differs   = (sample != acc_reg) || (run_next == cfg.thresh);
        acc_next  = acc_reg;
        left_next = left_reg;
        event_hit = 1'b0;
        if (differs)
        begin
            if (left_reg == '0)
            begin
                acc_next  = sample;
                event_hit = 1'b1;
            end
            else
            begin
                left_next = left_reg - {{(CNT_W-1){1'b0}}, 1'b1};
            end
        end
        else
        begin
            left_next = cfg.reload;
        end
    end

    assign state = acc_next;

    // Update lane state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= ST_HIGH;
            left_reg <= RELOAD_RESET;
            run_reg  <= '0;
        end
        else if (step)
        begin
            acc_reg  <= acc_next;
            left_reg <= left_next;
            run_reg  <= run_next;
        end
    end

endmodule

`default_nettype wire

### design/bdlp_merge.sv
// Merge stage: holds the packed lane result words in a two-entry buffer.
// Depends on bdlp_pkg for the result word type.
`default_nettype none

module bdlp_merge
    import bdlp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire out_word_t  word_in,
    output logic            space,
    output logic            out_valid,
    input  wire logic       out_ready,
    output out_word_t       word_out
);

    out_word_t   head_reg, head_next;
    out_word_t   tail_reg, tail_next;
    logic [1:0]  count_reg, count_next;
    logic        pop;

    assign space     = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign word_out  = head_reg;

    // Steer words into head and tail
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            if (count_reg == 2'd0)
                head_next = word_in;
            else
                tail_next = word_in;
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            head_next  = tail_reg;
            count_next = count_reg - 2'd1;
        end
        else if (push && pop)
        begin
            if (count_reg == 2'd1)
                head_next = word_in;
            else
            begin
                head_next = tail_reg;
                tail_next = word_in;
            end
        end
    end

    // Hold the fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    // Hold the buffered words
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

`default_nettype wire

### design/bdlp_checker.sv
// Port-level checker for the button debouncer, bound to the top level.
// Depends on bdlp_pkg and the assertion macros header.
`default_nettype none

`include "button_debounce_long_press_top_defines.svh"

module bdlp_checker
    import bdlp_pkg::*;
#(
    parameter int BUTTONS = BUTTONS_DEF
)
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    in_valid,
    input wire logic                    in_ready,
    input wire logic                    out_valid,
    input wire logic                    out_ready,
    input wire logic [MAX_BUTTONS-1:0]  event_mask,
    input wire logic [STATES_W-1:0]     button_states
);

    logic [MAX_BUTTONS-1:0] bad_pair;
    logic [MAX_BUTTONS-1:0] unused_lane;
    logic                   in_take;

    assign in_take = in_valid && in_ready;

    // Flag state codes outside low, high and long, and lanes beyond BUTTONS
    for (genvar i = 0; i < MAX_BUTTONS; i++)
    begin : g_pair
        assign bad_pair[i]    = (button_states[2*i +: 2] == 2'd3);
        assign unused_lane[i] = (i >= BUTTONS);
    end

    // A stalled result word holds
    `BDLP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(event_mask) && $stable(button_states))

    // Every accepted word leaves the output valid on the next cycle
    `BDLP_ASSERT_NEXT(a_result_follows, in_take, out_valid)

    // Result states are legal codes
    `BDLP_ASSERT_SAME(a_state_code, out_valid, bad_pair == '0)

    // Unused lanes never raise events
    `BDLP_ASSERT_SAME(a_unused_quiet, out_valid, (event_mask & unused_lane) == '0)

endmodule

bind button_debounce_long_press_top bdlp_checker #(.BUTTONS(BUTTONS)) u_bdlp_checker (.*);

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the debouncer with long-press detection: scan words in,
// one result word out per scan, predicted per button and compared field by field.
// Depends on bdlp_pkg and button_debounce_long_press_top.

module tb;
    import bdlp_pkg::*;

    localparam int LANES = BUTTONS_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_WORDS = 108;

    // Indexes that map to no register
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_HI = 2'd3;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [MAX_BUTTONS-1:0] pin_levels = '1;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [MAX_BUTTONS-1:0] event_mask;
    logic [STATES_W-1:0]    button_states;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_DEBOUNCE;
    logic [CNT_W-1:0]       cfg_data = '0;

    // Predicted block state and register copies
    logic [CNT_W-1:0] settle_count;
    logic [CNT_W-1:0] press_limit;
    btn_state_t       held_state [MAX_BUTTONS];
    logic [CNT_W-1:0] settle_left[MAX_BUTTONS];
    logic [CNT_W-1:0] press_run  [MAX_BUTTONS];

    out_word_t expected_words[$];
    int        mismatch_count = 0;
    bit        in_burst = 1'b0;
    bit        out_burst = 1'b0;

    button_debounce_long_press_top #(.BUTTONS(LANES)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pin_levels    (pin_levels),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_mask    (event_mask),
        .button_states (button_states),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Put the predicted state where reset leaves the block
    task automatic reset_debouncer_model();
        settle_count = DEBOUNCE_RESET;
        press_limit  = LONG_PRESS_RESET;
        for (int b = 0; b < MAX_BUTTONS; b++)
        begin
            held_state[b]  = ST_HIGH;
            settle_left[b] = DEBOUNCE_RESET - 8'd1;
            press_run[b]   = '0;
        end
    endtask

    // Advance every lane by one scan and return the word the block should emit
    function automatic out_word_t debounce_tick(input logic [MAX_BUTTONS-1:0] levels);
        out_word_t        word;
        btn_state_t       sample;
        int               run;
        int               limit;
        logic [CNT_W-1:0] reload;
        logic             moving;
        word   = '0;
        limit  = (press_limit == 0) ? 1 : int'(press_limit);
        reload = (settle_count == 0) ? 8'd0 : settle_count - 8'd1;
        for (int b = 0; b < LANES; b++)
        begin
            // Count the pressed run, saturating at the long-press threshold
            if (!levels[b])
            begin
                run    = int'(press_run[b]) + 1;
                sample = ST_LOW;
                if (run > limit)
                begin
                    run    = limit;
                    sample = ST_LONG;
                end
                press_run[b] = CNT_W'(run);
            end
            else
            begin
                sample       = ST_HIGH;
                press_run[b] = '0;
            end
            // Count down on a differing sample, accept at zero, else reload
            moving = (sample != held_state[b]) || (int'(press_run[b]) == limit);
            if (moving)
            begin
                if (settle_left[b] == 0)
                begin
                    held_state[b]      = sample;
                    word.event_mask[b] = 1'b1;
                end
                else
                    settle_left[b] = settle_left[b] - 8'd1;
            end
            else
                settle_left[b] = reload;
            word.button_states[2*b +: 2] = held_state[b];
        end
        return word;
    endfunction

    // Send one scan word after a random gap (none in a burst), then predict its result
    task automatic send_scan(input logic [MAX_BUTTONS-1:0] levels);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        pin_levels <= levels;
        do @(posedge clk); while (!in_ready);
        expected_words.push_back(debounce_tick(levels));
    endtask

    // Hold the input side until every predicted word has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_DEBOUNCE:   settle_count = value;
            REG_LONG_PRESS: press_limit  = value;
            default:        ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic note_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, got);
    endtask

    // Receiver: random stall before each word, none in a burst
    initial
    begin : result_sink
        int stall;
        @(posedge clk iff rst_n);
        forever
        begin
            stall = out_burst ? 0 : $urandom_range(0, 15);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin : check_words
        out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
                note_mismatch("unexpected word", 16'h0, {event_mask, 8'h0});
            else
            begin
                want = expected_words.pop_front();
                if (event_mask !== want.event_mask)
                    note_mismatch("event_mask", 16'(want.event_mask), 16'(event_mask));
                if (button_states !== want.button_states)
                    note_mismatch("button_states", want.button_states, button_states);
            end
        end
    end

    // Stop the run when nothing moves on any channel for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // Reset values: release, a full debounce of a press, mixed lanes
    task automatic test_reset_values();
        in_burst  = 1'b1;
        out_burst = 1'b1;
        send_scan(8'hFF);
        repeat (5) send_scan(8'h00);
        send_scan(8'hAA);
        send_scan(8'h55);
        drain_results();
        in_burst  = 1'b0;
        out_burst = 1'b0;
    endtask

    // Zero debounce count and zero threshold; writes to unmapped indexes
    task automatic test_degenerate_config();
        write_reg(REG_DEBOUNCE, 8'h00);
        write_reg(REG_LONG_PRESS, 8'h00);
        write_reg(REG_UNMAPPED_LO, 8'h00);
        write_reg(REG_UNMAPPED_HI, 8'hFF);
        repeat (3) send_scan(8'h00);
        send_scan(8'hFF);
        send_scan(8'h0F);
        send_scan(8'hF0);
        drain_results();
    endtask

    // Lower the threshold while buttons are held past it
    task automatic test_threshold_drop();
        write_reg(REG_DEBOUNCE, 8'd1);
        write_reg(REG_LONG_PRESS, 8'd12);
        repeat (10) send_scan(8'h00);
        drain_results();
        write_reg(REG_LONG_PRESS, 8'd3);
        repeat (2) send_scan(8'h00);
        repeat (2) send_scan(8'hFF);
        drain_results();
    endtask

    // Held patterns with bounce, over a range of register settings
    task automatic test_random_scans();
        logic [CNT_W-1:0]       dc_list[10];
        logic [CNT_W-1:0]       lp_list[10];
        logic [MAX_BUTTONS-1:0] base;
        logic [MAX_BUTTONS-1:0] levels;
        int                     left;
        int                     seg_max;
        dc_list = '{8'd1, 8'd2, 8'd255, 8'd1, 8'd255, 8'd3, 8'd0, 8'd5, 8'd1, 8'd4};
        lp_list = '{8'd1, 8'd4, 8'd255, 8'd255, 8'd1, 8'd10, 8'd0, 8'd50, 8'd2, 8'd20};
        dc_list[9] = CNT_W'($urandom_range(1, 6));
        lp_list[9] = CNT_W'($urandom_range(1, 30));
        base = 8'hFF;
        left = 0;
        for (int p = 0; p < 10; p++)
        begin
            write_reg(REG_DEBOUNCE, dc_list[p]);
            write_reg(REG_LONG_PRESS, lp_list[p]);
            in_burst  = ($urandom_range(0, 2) == 0);
            out_burst = ($urandom_range(0, 2) == 0);
            seg_max   = int'(lp_list[p]) + int'(dc_list[p]) + 4;
            if (seg_max > 80)
                seg_max = 80;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // Pick a new held pattern when the current one runs out
                if (left == 0)
                begin
                    case ($urandom_range(0, 3))
                        0: base = MAX_BUTTONS'($urandom);
                        1: base = base ^ MAX_BUTTONS'(1 << $urandom_range(0, 7));
                        2: base = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
                        default: base = base ^ MAX_BUTTONS'($urandom);
                    endcase
                    left = $urandom_range(1, seg_max);
                end
                levels = base;
                // Bounce one contact now and then
                if ($urandom_range(0, 9) == 0)
                    levels = levels ^ MAX_BUTTONS'(1 << $urandom_range(0, 7));
                left--;
                send_scan(levels);
            end
            drain_results();
        end
        in_burst  = 1'b0;
        out_burst = 1'b0;
    endtask

    initial
    begin
        reset_debouncer_model();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_degenerate_config();
        test_threshold_drop();
        test_random_scans();
        drain_results();
        repeat (4) @(posedge clk);
        mismatch_count += expected_words.size();
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
